@@ rtl/core/pcft_pkg.sv @@
// ----------------------------------------------------------------------------
// pcft_pkg
// Shared types, constants and helpers for the pressure compensation block.
// ----------------------------------------------------------------------------
package pcft_pkg;

	localparam int RAW_W = 16;
	localparam int RES_W = 13;
	localparam int IDX_W = 8;
	localparam int DAT_W = 32;

	// register indexes
	localparam logic [IDX_W-1:0] REG_P1   = 8'd0;
	localparam logic [IDX_W-1:0] REG_P2   = 8'd1;
	localparam logic [IDX_W-1:0] REG_P3   = 8'd2;
	localparam logic [IDX_W-1:0] REG_P4   = 8'd3;
	localparam logic [IDX_W-1:0] REG_P5   = 8'd4;
	localparam logic [IDX_W-1:0] REG_P6   = 8'd5;
	localparam logic [IDX_W-1:0] REG_P7   = 8'd6;
	localparam logic [IDX_W-1:0] REG_P8P9 = 8'd7;

	// terms of the fixed temperature (t_fine = 102374)
	localparam logic signed [31:0] K_SQ2048 = 32'sd5009;    // (var1/4)^2 / 2048
	localparam logic signed [31:0] K_A2     = -32'sd25626;  // 2 * var1
	localparam logic signed [31:0] K_SQ8192 = 32'sd1252;    // (var1/4)^2 / 8192
	localparam logic signed [31:0] K_A      = -32'sd12813;  // var1

	localparam logic [31:0] P_BASE  = 32'd1048576;
	localparam logic [31:0] P_SCALE = 32'd3125;
	localparam logic [31:0] P_MIN   = 32'd30000;
	localparam logic [31:0] P_MAX   = 32'd110000;

	typedef struct packed {
		logic dbl;   // double the quotient afterwards
		logic zero;  // divisor was zero
	} pcft_side_t;

	// low 32 bits of a 32 x 32 product
	function automatic logic signed [31:0] mul32(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		return p[31:0];
	endfunction

	// signed divide by 2^k, truncating toward zero
	function automatic logic signed [31:0] divt(input logic signed [31:0] x, input int k);
		logic signed [31:0] bias;
		bias = x[31] ? ((32'sd1 <<< k) - 32'sd1) : 32'sd0;
		return (x + bias) >>> k;
	endfunction

endpackage

@@ rtl/core/pcft_if.sv @@
// ----------------------------------------------------------------------------
// pcft_if
// Channel interfaces: sample in, result out, configuration write.
// ----------------------------------------------------------------------------
interface pcft_in_if;
	import pcft_pkg::*;
	logic             valid;
	logic             ready;
	logic [RAW_W-1:0] raw_pressure;
	modport source (output valid, output raw_pressure, input ready);
	modport sink   (input valid, input raw_pressure, output ready);
endinterface

interface pcft_out_if;
	import pcft_pkg::*;
	logic             valid;
	logic             ready;
	logic [RES_W-1:0] pressure_sixteenths;
	modport source (output valid, output pressure_sixteenths, input ready);
	modport sink   (input valid, input pressure_sixteenths, output ready);
endinterface

interface pcft_cfg_if;
	import pcft_pkg::*;
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] index;
	logic [DAT_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/pressure_compensation_fixed_temp.sv @@
// ----------------------------------------------------------------------------
// pressure_compensation_fixed_temp
// Integer pressure compensation of raw samples at a fixed 20.00 C.
// ----------------------------------------------------------------------------
// Usage:
//   smp carries raw_pressure samples in, res carries pressure_sixteenths out,
//   one result per sample, in order. cfg writes the calibration registers
//   (index 0..7, others ignored); it is always ready and must only be used
//   while no sample is in flight.
//   From the smp transfer to res valid a sample passes 38 registers (the
//   first loaded by the transfer edge itself): three stages for the
//   calibration terms and numerator, 32 stages of the restoring divider
//   (one quotient bit each), three stages of final correction and clamp.
//   Throughput is one sample per cycle while res is not stalled.
//   Reset clears all coefficients to zero and empties the pipeline.
//   When the receiver holds off res.ready with a result waiting, the whole
//   pipeline freezes and smp.ready drops; nothing is lost or repeated.
//   A zero divisor term yields the minimum, 1875.
// ----------------------------------------------------------------------------
module pressure_compensation_fixed_temp (
	input logic clk,
	input logic arst_n,
	pcft_in_if.sink    smp,
	pcft_out_if.source res,
	pcft_cfg_if.sink   cfg
);
	import pcft_pkg::*;

	logic [15:0] p1_q, p2_q, p3_q, p4_q, p5_q, p6_q, p7_q;
	logic [31:0] p89_q;
	logic signed [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
	logic en;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p1_q <= '0; p2_q <= '0; p3_q <= '0; p4_q <= '0;
			p5_q <= '0; p6_q <= '0; p7_q <= '0; p89_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_P1:   p1_q  <= cfg.data[15:0];
				REG_P2:   p2_q  <= cfg.data[15:0];
				REG_P3:   p3_q  <= cfg.data[15:0];
				REG_P4:   p4_q  <= cfg.data[15:0];
				REG_P5:   p5_q  <= cfg.data[15:0];
				REG_P6:   p6_q  <= cfg.data[15:0];
				REG_P7:   p7_q  <= cfg.data[15:0];
				REG_P8P9: p89_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign p1 = {16'b0, p1_q};
	assign p2 = {{16{p2_q[15]}}, p2_q};
	assign p3 = {{16{p3_q[15]}}, p3_q};
	assign p4 = {{16{p4_q[15]}}, p4_q};
	assign p5 = {{16{p5_q[15]}}, p5_q};
	assign p6 = {{16{p6_q[15]}}, p6_q};
	assign p7 = {{16{p7_q[15]}}, p7_q};
	assign p8 = {{16{p89_q[15]}}, p89_q[15:0]};
	assign p9 = {{16{p89_q[31]}}, p89_q[31:16]};

	// stall every stage together while a result waits
	logic v_out_s;
	assign en        = !v_out_s || res.ready;
	assign smp.ready = en;

	// stage 1: calibration products
	logic v_s1;
	logic [15:0] raw_s1;
	logic signed [31:0] m1_s1, m2_s1, m3_s1, m4_s1;
	// stage 2: offset and divisor terms
	logic v_s2;
	logic [15:0] raw_s2;
	logic signed [31:0] b_s2, a2_s2;
	// stage 3: divisor and numerator
	logic v_s3;
	logic [31:0] div_s3, pr_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= smp.valid; v_s2 <= v_s1; v_s3 <= v_s2;
		end
	end

	logic signed [31:0] c_t, d_t, cd_t, bsum_t, a3_t, bq_t;
	logic [31:0] num_t;
	always_comb begin
		bsum_t = divt(m1_s1 + m2_s1, 2) + (p4 <<< 16);
		c_t    = divt(m3_s1, 3);
		d_t    = divt(m4_s1, 1);
		cd_t   = divt(c_t + d_t, 18);
		a3_t   = divt(mul32(32'sd32768 + a2_s2, p1), 15);
		bq_t   = divt(b_s2, 12);
		num_t  = P_BASE - {12'b0, raw_s2, 4'b0} - bq_t;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			raw_s1 <= smp.raw_pressure;
			m1_s1  <= mul32(p6, K_SQ2048);
			m2_s1  <= mul32(p5, K_A2);
			m3_s1  <= mul32(p3, K_SQ8192);
			m4_s1  <= mul32(p2, K_A);
			raw_s2 <= raw_s1;
			b_s2   <= bsum_t;
			a2_s2  <= cd_t;
			div_s3 <= a3_t;
			pr_s3  <= mul32(num_t, P_SCALE);
		end
	end

	// split divide: double the dividend below 2^31, else the quotient
	pcft_side_t side_in, side_dv;
	logic [31:0] num_dv, quo_dv;
	logic v_dv;
	assign side_in.dbl  = pr_s3[31];
	assign side_in.zero = (div_s3 == 32'd0);
	assign num_dv       = pr_s3[31] ? pr_s3 : {pr_s3[30:0], 1'b0};

	pcft_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vin      (v_s3),
		.num      (num_dv),
		.den      (div_s3),
		.side_in  (side_in),
		.vout     (v_dv),
		.quo      (quo_dv),
		.side_out (side_dv)
	);

	// final correction
	logic v_s4, v_s5;
	logic zero_s4, zero_s5;
	logic [31:0] pr_s4, pr_s5, sq_s4;
	logic signed [31:0] ft_s4, ep_s5, f_s5;
	logic [31:0] prq_t;
	logic signed [31:0] e_t, g_t;
	logic [31:0] fin_t, clamp_t;
	logic [RES_W-1:0] res_q;

	assign prq_t = side_dv.dbl ? {quo_dv[30:0], 1'b0} : quo_dv;

	always_comb begin
		e_t   = divt(ep_s5, 12);
		g_t   = divt(e_t + f_s5 + p7, 4);
		fin_t = pr_s5 + g_t;
		if (zero_s5 || fin_t < P_MIN) begin
			clamp_t = P_MIN;
		end else if (fin_t > P_MAX) begin
			clamp_t = P_MAX;
		end else begin
			clamp_t = fin_t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_out_s <= 1'b0;
		end else if (en) begin
			v_s4 <= v_dv; v_s5 <= v_s4; v_out_s <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s4 <= side_dv.zero;
			pr_s4   <= prq_t;
			sq_s4   <= mul32({3'b0, prq_t[31:3]}, {3'b0, prq_t[31:3]});
			ft_s4   <= mul32({2'b0, prq_t[31:2]}, p8);
			zero_s5 <= zero_s4;
			pr_s5   <= pr_s4;
			ep_s5   <= mul32({13'b0, sq_s4[31:13]}, p9);
			f_s5    <= divt(ft_s4, 13);
			res_q   <= clamp_t[16:4];
		end
	end

	assign res.valid               = v_out_s;
	assign res.pressure_sixteenths = res_q;

endmodule

@@ rtl/core/pcft_div.sv @@
// ----------------------------------------------------------------------------
// pcft_div
// Pipelined 32-bit unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module pcft_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               vin,
	input  logic [31:0]        num,
	input  logic [31:0]        den,
	input  pcft_pkg::pcft_side_t side_in,
	output logic               vout,
	output logic [31:0]        quo,
	output pcft_pkg::pcft_side_t side_out
);
	import pcft_pkg::*;

	localparam int N = 32;

	logic             v_s    [0:N];
	logic [31:0]      rem_s  [0:N];
	logic [31:0]      num_s  [0:N];
	logic [31:0]      quo_s  [0:N];
	logic [31:0]      den_s  [0:N];
	pcft_side_t       side_s [0:N];

	assign v_s[0]    = vin;
	assign rem_s[0]  = '0;
	assign num_s[0]  = num;
	assign quo_s[0]  = '0;
	assign den_s[0]  = den;
	assign side_s[0] = side_in;

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [32:0] trial;
		logic [32:0] diff;
		logic        take;
		assign trial = {rem_s[k], num_s[k][31]};
		assign diff  = trial - {1'b0, den_s[k]};
		assign take  = !diff[32];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= take ? diff[31:0] : trial[31:0];
				num_s[k+1]  <= {num_s[k][30:0], 1'b0};
				quo_s[k+1]  <= {quo_s[k][30:0], take};
				den_s[k+1]  <= den_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign vout     = v_s[N];
	assign quo      = quo_s[N];
	assign side_out = side_s[N];

endmodule

@@ rtl/core/pcft_chk.sv @@
// ----------------------------------------------------------------------------
// pcft_chk
// Port-level checks for the pressure compensation block.
// ----------------------------------------------------------------------------
module pcft_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [12:0] out_data,
	input logic        cfg_ready
);
	// results always lie inside the clamp range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data >= 13'd1875 && out_data <= 13'd6875))
		else $error("result outside clamp range");

	// an empty output never blocks the input
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port not ready");

	a_hold_v: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_hold_d: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result changed while stalled");
endmodule

bind pressure_compensation_fixed_temp pcft_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (smp.ready),
	.out_valid (res.valid),
	.out_ready (res.ready),
	.out_data  (res.pressure_sixteenths),
	.cfg_ready (cfg.ready)
);
